// File: design/uer_pkg.sv
// Package for the ultrasonic echo ranger: phase codes, status codes,
// register indexes, configuration and result structs. No dependencies.
package uer_pkg;

	typedef enum logic [2:0] {
		PH_IDLE      = 3'd0,
		PH_TRIG_LOW  = 3'd1,
		PH_TRIG_HIGH = 3'd2,
		PH_WAIT_RISE = 3'd3,
		PH_MEASURE   = 3'd4
	} phase_t;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_TIMEOUT = 2'd1;
	localparam logic [1:0] ST_RANGE   = 2'd2;

	localparam logic [1:0] REG_TIMEOUT   = 2'd0;
	localparam logic [1:0] REG_MAX_RANGE = 2'd1;
	localparam logic [1:0] REG_TRIGGER   = 2'd2;

	localparam logic [15:0] TIMEOUT_RST   = 16'd10000;
	localparam logic [15:0] MAX_RANGE_RST = 16'd1000;
	localparam logic [7:0]  TRIGGER_RST   = 8'd10;

	// Half the echo width times 351/1024 approximates 0.343 mm per microsecond.
	localparam logic [8:0] SPEED_NUM   = 9'd351;
	localparam int         SPEED_SHIFT = 10;

	localparam int IN_TDATA_W  = 8;
	localparam int OUT_TDATA_W = 24;

	typedef struct packed {
		logic [15:0] timeout_ticks;
		logic [15:0] max_range_mm;
		logic [7:0]  trigger_ticks;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [15:0] distance_mm;
		logic        result_ready;
		logic        trigger_level;
	} result_t;

endpackage

// File: design/ultrasonic_echo_ranger_unit.sv
// Ultrasonic echo ranger top level: input register, sequencer, result register.
// A request is registered in the input register, its result then in the result register;
// one request per cycle unless the master side stalls, set by the sequencer step.
// Reset is asynchronous and active low; it clears the phase machine, counters,
// stage valids and loads the configuration registers with their default values.
// Depends on uer_pkg, uer_cfg and uer_core.
module ultrasonic_echo_ranger_unit import uer_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_tvalid,
	output logic                   s_tready,
	input  logic [IN_TDATA_W-1:0]  s_tdata,  // [0] start_req, [1] echo_level, rest zero
	output logic                   m_tvalid,
	input  logic                   m_tready,
	output logic [OUT_TDATA_W-1:0] m_tdata,  // [0] trigger_level, [1] result_ready,
	                                         // [17:2] distance_mm, [19:18] status, rest zero
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [1:0]             cfg_index,
	input  logic [15:0]            cfg_data
);

	cfg_t    cfg;
	result_t res;

	logic    s1_valid_s1;
	logic    start_s1;
	logic    echo_s1;
	logic    out_valid_q;
	result_t out_q;
	logic    advance;
	logic    step;

	assign cfg_ready = 1'b1;
	assign advance   = !out_valid_q || m_tready;
	assign step      = s1_valid_s1 && advance;
	assign s_tready  = !s1_valid_s1 || advance;

	uer_cfg u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid && cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	uer_core u_core (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (step),
		.start_req  (start_s1),
		.echo_level (echo_s1),
		.cfg        (cfg),
		.res        (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s_tready) begin
				s1_valid_s1 <= s_tvalid;
			end
			if (advance) begin
				out_valid_q <= s1_valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			start_s1 <= s_tdata[0];
			echo_s1  <= s_tdata[1];
		end
		if (step) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(OUT_TDATA_W - $bits(result_t)){1'b0}}, out_q};

endmodule

// File: design/uer_cfg.sv
// Configuration register file of the ultrasonic echo ranger.
// Depends on uer_pkg for register indexes, reset values and cfg_t.
module uer_cfg import uer_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        wr_en,
	input  logic [1:0]  wr_index,
	input  logic [15:0] wr_data,
	output cfg_t        cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.timeout_ticks <= TIMEOUT_RST;
			cfg_q.max_range_mm  <= MAX_RANGE_RST;
			cfg_q.trigger_ticks <= TRIGGER_RST;
		end else if (wr_en) begin
			case (wr_index)
				REG_TIMEOUT: begin
					cfg_q.timeout_ticks <= wr_data;
				end
				REG_MAX_RANGE: begin
					cfg_q.max_range_mm <= wr_data;
				end
				REG_TRIGGER: begin
					cfg_q.trigger_ticks <= wr_data[7:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// File: design/uer_core.sv
// Measurement sequencer of the ultrasonic echo ranger: phase machine, tick and
// pulse counters, and the distance calculation for one tick. Depends on uer_pkg.
module uer_core import uer_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    step,
	input  logic    start_req,
	input  logic    echo_level,
	input  cfg_t    cfg,
	output result_t res
);

	phase_t      phase_q, phase_d;
	logic [15:0] tick_q, tick_d;
	logic [15:0] width_q, width_d;
	logic        echo_prev_q;

	logic [15:0] tick_inc;
	logic [15:0] width_inc;
	logic [23:0] product;
	logic [15:0] dist_mm;
	logic        rise;
	logic        done;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_IDLE;
			tick_q      <= '0;
			width_q     <= '0;
			echo_prev_q <= 1'b0;
		end else if (step) begin
			phase_q     <= phase_d;
			tick_q      <= tick_d;
			width_q     <= width_d;
			echo_prev_q <= echo_level;
		end
	end

	assign tick_inc  = (tick_q == 16'hFFFF) ? tick_q : tick_q + 16'd1;
	assign width_inc = (width_q == 16'hFFFF) ? width_q : width_q + 16'd1;
	assign rise      = echo_level && !echo_prev_q;
	// The widest pulse gives at most 11231 mm, so the result never saturates.
	assign product   = 24'(width_inc[15:1]) * 24'(SPEED_NUM);
	assign dist_mm   = 16'(product[23:SPEED_SHIFT]);

	always_comb begin
		phase_d = phase_q;
		tick_d  = tick_q;
		width_d = width_q;
		done    = 1'b0;
		res     = '0;
		case (phase_q)
			PH_IDLE: begin
				if (start_req) begin
					phase_d = PH_TRIG_LOW;
					tick_d  = '0;
				end
			end
			PH_TRIG_LOW, PH_TRIG_HIGH: begin
				res.trigger_level = (phase_q == PH_TRIG_HIGH);
				tick_d = tick_inc;
				if (tick_inc >= {8'd0, cfg.trigger_ticks}) begin
					phase_d = (phase_q == PH_TRIG_LOW) ? PH_TRIG_HIGH : PH_WAIT_RISE;
					tick_d  = '0;
				end
			end
			PH_WAIT_RISE, PH_MEASURE: begin
				tick_d = tick_inc;
				if (phase_q == PH_WAIT_RISE) begin
					if (rise) begin
						phase_d = PH_MEASURE;
						width_d = '0;
					end
				end else begin
					width_d = width_inc;
					if (!echo_level) begin
						res.result_ready = 1'b1;
						done = 1'b1;
						if (dist_mm >= cfg.max_range_mm) begin
							res.status = ST_RANGE;
						end else begin
							res.distance_mm = dist_mm;
						end
					end
				end
				if (!done && tick_inc >= cfg.timeout_ticks) begin
					res.result_ready = 1'b1;
					res.status = ST_TIMEOUT;
					done = 1'b1;
				end
				if (done) begin
					phase_d = PH_IDLE;
					tick_d  = '0;
				end
			end
			default: begin
				phase_d = PH_IDLE;
				tick_d  = '0;
			end
		endcase
	end

endmodule

// File: verif/tb.sv
// Self-checking testbench for ultrasonic_echo_ranger_unit: a tick stream with
// measurements, noise and register writes is checked against a cycle model.
// Depends on uer_pkg and the design sources.
`timescale 1ns / 100ps

module tb;
	import uer_pkg::*;

	typedef struct packed {
		logic echo_level;
		logic start_req;
	} tick_t;

	typedef struct packed {
		logic [1:0]  index;
		logic [15:0] data;
	} reg_write_t;

	localparam logic [1:0] REG_UNUSED = 2'd3;
	localparam int unsigned HOLD_CYCLES = 120;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_tvalid = 1'b0;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata = '0;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   cfg_valid = 1'b0;
	logic                   cfg_ready;
	logic [1:0]             cfg_index = REG_TIMEOUT;
	logic [15:0]            cfg_data = '0;

	tick_t      pending_ticks[$];
	result_t    expected_results[$];
	reg_write_t reg_writes[$];

	int          n_pushed = 0;
	int          n_mismatch = 0;
	int unsigned cyc = 0;
	int unsigned hold_left = 0;
	logic        hold_go = 1'b0;
	wire         quiet = (cyc % 1000) < 250;

	// Model state and the register values it sees.
	phase_t      rng_phase = PH_IDLE;
	logic [15:0] rng_ticks = '0;
	logic [15:0] rng_width = '0;
	logic        rng_echo_q = 1'b0;
	logic [15:0] cur_timeout = TIMEOUT_RST;
	logic [15:0] cur_max_range = MAX_RANGE_RST;
	logic [7:0]  cur_trigger = TRIGGER_RST;

	ultrasonic_echo_ranger_unit i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	always @(posedge clk) begin
		cyc <= cyc + 1;
	end

	function automatic logic [15:0] bump16(logic [15:0] v);
		return (v == 16'hFFFF) ? v : v + 16'd1;
	endfunction

	// Advances the ranger by one tick and returns what it reports for that tick.
	function automatic result_t ranger_step(tick_t t);
		result_t     r;
		logic        rise;
		logic        done;
		logic [31:0] d;
		r = '0;
		done = 1'b0;
		rise = t.echo_level && !rng_echo_q;
		case (rng_phase)
			PH_IDLE: begin
				if (t.start_req) begin
					rng_phase = PH_TRIG_LOW;
					rng_ticks = '0;
				end
			end
			PH_TRIG_LOW, PH_TRIG_HIGH: begin
				r.trigger_level = (rng_phase == PH_TRIG_HIGH);
				rng_ticks = bump16(rng_ticks);
				if (rng_ticks >= {8'd0, cur_trigger}) begin
					rng_phase = (rng_phase == PH_TRIG_LOW) ? PH_TRIG_HIGH : PH_WAIT_RISE;
					rng_ticks = '0;
				end
			end
			PH_WAIT_RISE, PH_MEASURE: begin
				rng_ticks = bump16(rng_ticks);
				if (rng_phase == PH_WAIT_RISE) begin
					if (rise) begin
						rng_phase = PH_MEASURE;
						rng_width = '0;
					end
				end else begin
					rng_width = bump16(rng_width);
					if (!t.echo_level) begin
						d = ((32'(rng_width) >> 1) * SPEED_NUM) >> SPEED_SHIFT;
						if (d > 32'h0000FFFF) begin
							d = 32'h0000FFFF;
						end
						r.result_ready = 1'b1;
						done = 1'b1;
						if (d >= {16'd0, cur_max_range}) begin
							r.status = ST_RANGE;
						end else begin
							r.distance_mm = d[15:0];
						end
					end
				end
				// A falling edge on the deadline tick still counts as a measurement.
				if (!done && rng_ticks >= cur_timeout) begin
					r.result_ready = 1'b1;
					r.status = ST_TIMEOUT;
					done = 1'b1;
				end
				if (done) begin
					rng_phase = PH_IDLE;
					rng_ticks = '0;
				end
			end
			default: begin
				rng_phase = PH_IDLE;
				rng_ticks = '0;
			end
		endcase
		rng_echo_q = t.echo_level;
		return r;
	endfunction

	task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
		if (n_mismatch < 40) begin
			$display("mismatch in %s: got 0x%0h, expected 0x%0h", what, got, want);
		end
		n_mismatch++;
	endtask

	// Each accepted request advances the ranger model by one tick.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			s_tdata <= '0;
		end else begin
			if (s_tvalid && s_tready) begin
				expected_results.push_back(ranger_step(tick_t'(s_tdata[1:0])));
			end
			if (!s_tvalid || s_tready) begin
				if (pending_ticks.size() != 0 && (quiet || $urandom_range(0, 99) >= 15)) begin
					s_tvalid <= 1'b1;
					s_tdata <= {{(IN_TDATA_W - 2){1'b0}}, pending_ticks.pop_front()};
				end else begin
					s_tvalid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin : reg_driver
		reg_write_t w;
		if (!arst_n) begin
			cfg_valid <= 1'b0;
			cfg_index <= REG_TIMEOUT;
			cfg_data <= '0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_TIMEOUT:   cur_timeout = cfg_data;
					REG_MAX_RANGE: cur_max_range = cfg_data;
					REG_TRIGGER:   cur_trigger = cfg_data[7:0];
					default: ;
				endcase
			end
			if (!cfg_valid || cfg_ready) begin
				if (reg_writes.size() != 0) begin
					w = reg_writes.pop_front();
					cfg_valid <= 1'b1;
					cfg_index <= w.index;
					cfg_data <= w.data;
				end else begin
					cfg_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_left <= 0;
		end else if (hold_go) begin
			hold_left <= HOLD_CYCLES;
		end else if (hold_left != 0) begin
			hold_left <= hold_left - 1;
		end
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else if (hold_left != 0) begin
			m_tready <= 1'b0;
		end else begin
			m_tready <= quiet || $urandom_range(0, 99) >= 15;
		end
	end

	always @(posedge clk) begin : result_monitor
		result_t got;
		result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			got = result_t'(m_tdata[19:0]);
			if (expected_results.size() == 0) begin
				flag_mismatch("unexpected result", 32'(m_tdata), 32'd0);
			end else begin
				want = expected_results.pop_front();
				if (got.trigger_level !== want.trigger_level) begin
					flag_mismatch("trigger_level", 32'(got.trigger_level), 32'(want.trigger_level));
				end
				if (got.result_ready !== want.result_ready) begin
					flag_mismatch("result_ready", 32'(got.result_ready), 32'(want.result_ready));
				end
				if (got.distance_mm !== want.distance_mm) begin
					flag_mismatch("distance_mm", 32'(got.distance_mm), 32'(want.distance_mm));
				end
				if (got.status !== want.status) begin
					flag_mismatch("status", 32'(got.status), 32'(want.status));
				end
				if (m_tdata[OUT_TDATA_W-1:20] !== '0) begin
					flag_mismatch("tdata padding", 32'(m_tdata[OUT_TDATA_W-1:20]), 32'd0);
				end
			end
		end
	end

	task automatic push_tick(logic start, logic echo);
		pending_ticks.push_back(tick_t'({echo, start}));
		n_pushed++;
	endtask

	task automatic wait_drained();
		while (pending_ticks.size() != 0 || s_tvalid || expected_results.size() != 0) begin
			@(negedge clk);
		end
	endtask

	task automatic configure(logic [15:0] tmo, logic [15:0] rng, logic [15:0] trig_word);
		wait_drained();
		repeat (4) @(negedge clk);
		reg_writes.push_back(reg_write_t'({REG_TIMEOUT, tmo}));
		reg_writes.push_back(reg_write_t'({REG_MAX_RANGE, rng}));
		reg_writes.push_back(reg_write_t'({REG_TRIGGER, trig_word}));
		while (reg_writes.size() != 0 || cfg_valid) begin
			@(negedge clk);
		end
	endtask

	// One trigger sequence followed by an echo pattern; some end in a timeout.
	task automatic push_measure(int trig, int tmo);
		int gap;
		int width;
		repeat ($urandom_range(0, 2)) push_tick(1'b0, 1'($urandom_range(0, 1)));
		push_tick(1'b1, 1'($urandom_range(0, 1)));
		repeat ((trig == 0) ? 2 : 2 * trig) begin
			push_tick($urandom_range(0, 3) == 0, 1'($urandom_range(0, 1)));
		end
		if ($urandom_range(0, 3) == 0) begin
			gap = ((tmo > 90) ? 90 : tmo) + 1;
		end else begin
			gap = $urandom_range(0, 6);
		end
		repeat (gap) push_tick(1'b0, 1'b0);
		width = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 40);
		repeat (width) push_tick(1'b0, 1'b1);
		push_tick(1'b0, 1'b0);
		if ($urandom_range(0, 99) < 15) begin
			repeat ($urandom_range(1, 8)) begin
				push_tick(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
			end
		end
	endtask

	initial begin : stimulus
		int          base;
		logic [15:0] tmo;
		logic [15:0] rng;
		logic [7:0]  trig;
		repeat (11) @(posedge clk);
		@(negedge clk) arst_n = 1'b1;

		// Register defaults: full trigger sequence, start requests while busy, short echo.
		push_tick(1'b1, 1'b0);
		for (int i = 0; i < 20; i++) begin
			push_tick(i == 7, i % 4 == 1);
		end
		push_tick(1'b0, 1'b1);
		push_tick(1'b0, 1'b1);
		push_tick(1'b0, 1'b0);

		// A trigger length of zero, echo already high when waiting begins, and a
		// falling edge on the deadline tick. The unused register index is ignored.
		wait_drained();
		reg_writes.push_back(reg_write_t'({REG_UNUSED, 16'hA5A5}));
		configure(16'd4, 16'hFFFF, 16'd0);
		push_tick(1'b1, 1'b1);
		push_tick(1'b0, 1'b1);
		push_tick(1'b0, 1'b1);
		push_tick(1'b0, 1'b1);
		push_tick(1'b0, 1'b0);
		push_tick(1'b0, 1'b1);
		push_tick(1'b0, 1'b0);

		for (int ph = 0; ph < 12; ph++) begin
			case (ph)
				0: begin
					tmo = 16'd0;
					rng = 16'd0;
					trig = 8'd0;
				end
				1: begin
					tmo = 16'd1;
					rng = 16'($urandom_range(0, 12));
					trig = 8'd1;
				end
				2: begin
					tmo = 16'hFFFF;
					rng = 16'hFFFF;
					trig = 8'd20;
				end
				3: begin
					tmo = 16'd40;
					rng = 16'd0;
					trig = 8'd2;
				end
				default: begin
					tmo = 16'($urandom_range(1, 60));
					rng = 16'($urandom_range(0, 12));
					trig = 8'($urandom_range(1, 3));
				end
			endcase
			configure(tmo, rng, {8'($urandom_range(0, 255)), trig});
			base = n_pushed;
			if (ph == 2) begin
				push_measure(trig, tmo);
			end else begin
				while (n_pushed - base < 12) push_measure(trig, tmo);
				if (ph == 6) begin
					wait_drained();
				end
				while (n_pushed - base < 24) push_measure(trig, tmo);
				if (ph == 4) begin
					@(posedge clk);
					hold_go <= 1'b1;
					@(posedge clk);
					hold_go <= 1'b0;
				end
			end
		end

		wait_drained();
		repeat (8) @(negedge clk);
		if (n_mismatch == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

	initial begin
		#2_000_000;
		$display("[FAIL] regression broken");
		$finish;
	end

endmodule
